FILE: rtl/bptri_pkg.sv
// Package for the bucketed position-to-record index block.
// Holds default sizes, request and status codes, and the controller/datapath structs.
// No dependencies.
package bptri_pkg;

   localparam int DEF_MAX_STRINGS = 256;
   localparam int DEF_POS_BITS    = 24;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_NOT_READY = 2'd3;

   typedef struct packed {
      logic take_load;
      logic take_lookup;
      logic set_nr;
      logic set_ovf;
      logic div_start;
      logic build_init;
      logic build_rd;
      logic build_step;
      logic bkt_rd;
      logic lk_init;
      logic so_rd;
      logic lk_next;
      logic set_nf;
      logic set_hit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic table_ready;
      logic ovf;
      logic div_done;
      logic lk_mode;
      logic in_range;
      logic adv;
      logic fin;
      logic more;
      logic hit;
      logic out_busy;
   } stat_type;

endpackage

FILE: rtl/bptri_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath for the span and the bucket number.
module bptri_div #(
   parameter int W = 25
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder,
   output logic         done
);

   localparam int CNTW = $clog2(W + 1);

   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    den_ff, den_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [W:0]      shifted;
   logic            take;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      take    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? W'(shifted - {1'b0, den_ff}) : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

FILE: rtl/bptri_dp.sv
// Datapath: offset and bucket memories, load accumulator, build and scan registers,
// and the result register. Depends on bptri_pkg and bptri_div.
module bptri_dp import bptri_pkg::*; #(
   parameter int MAX_STRINGS = DEF_MAX_STRINGS,
   parameter int POS_BITS    = DEF_POS_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            st,
   input  logic [POS_BITS-1:0] req_str_length,
   input  logic [POS_BITS-1:0] req_position,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_string_index,
   output logic [POS_BITS-1:0] rsp_joined_size,
   output logic [POS_BITS-1:0] rsp_bucket_span
);

   localparam int P    = POS_BITS;
   localparam int DW   = P + 1;
   localparam int RW   = P + 2;
   localparam int IW   = $clog2(MAX_STRINGS);
   localparam int AW   = $clog2(MAX_STRINGS + 1);
   localparam int LW   = IW + 2;
   localparam int CMPW = (DW > AW) ? DW : AW;
   localparam logic [RW-1:0] LIMIT = RW'(1) << P;

   logic [DW-1:0]    so_mem  [MAX_STRINGS+1];
   logic [IW+AW-1:0] bkt_mem [MAX_STRINGS];

   logic [AW-1:0] sl_ff, sl_in;
   logic [RW-1:0] rt_ff, rt_in;
   logic [DW-1:0] span_ff, span_in;
   logic          tr_ff, tr_in;
   logic          lk_mode_ff, lk_mode_in;
   logic [P-1:0]  pos_ff, pos_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [AW-1:0] seq_ff, seq_in;
   logic [IW-1:0] first_ff, first_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] bstart_ff, bstart_in;
   logic [RW-1:0] bend_ff, bend_in;
   logic [DW-1:0] lo_off_ff, lo_off_in;
   logic [IW-1:0] last_bkt_ff, last_bkt_in;
   logic          bvalid_ff;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] end_ff, end_in;
   logic [DW-1:0] rda_ff, rdb_ff;
   logic [IW+AW-1:0] bkt_rd_ff;
   logic [1:0]    res_status_ff, res_status_in;
   logic [LW-1:0] res_idx_ff, res_idx_in;
   logic [P-1:0]  res_jsz_ff, res_jsz_in;
   logic [P-1:0]  res_span_ff, res_span_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    out_status_ff;
   logic [LW-1:0] out_idx_ff;
   logic [P-1:0]  out_jsz_ff, out_span_ff;

   logic [AW-1:0]   sl_base;
   logic [RW-1:0]   rt_base, sum, rt_sat;
   logic            room;
   logic [DW-1:0]   div_a, div_b, quo, rem, span_new;
   logic            div_done;
   logic [CMPW-1:0] n_ext, q_ext;
   logic [IW-1:0]   seg;
   logic            cond_cnt, adv, fin, hit, more;
   logic [AW-1:0]   cntx;
   logic [AW-1:0]   rdb_addr;
   logic [DW-1:0]   lower;
   logic [IW-1:0]   bfirst;
   logic [AW-1:0]   bcount;
   logic [P-1:0]    jsz;
   logic [LW+7:0]   idx_ext;

   assign sl_base = tr_ff ? '0 : sl_ff;
   assign rt_base = tr_ff ? '0 : rt_ff;
   assign sum     = rt_base + RW'(req_str_length) + RW'(1);
   assign rt_sat  = (sum > LIMIT) ? LIMIT + RW'(1) : sum;
   assign room    = sl_base < AW'(MAX_STRINGS);

   assign n_ext = CMPW'(sl_ff);
   assign div_a = lk_mode_ff ? {1'b0, pos_ff} : rt_ff[DW-1:0];
   assign div_b = lk_mode_ff ? span_ff : n_ext[DW-1:0];

   bptri_div #(.W(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .quotient  (quo),
      .remainder (rem),
      .done      (div_done)
   );

   assign span_new = quo + DW'(rem != '0);
   assign q_ext    = CMPW'(quo);
   assign seg      = q_ext[IW-1:0];

   assign cond_cnt = ({1'b0, lo_off_ff} < bend_ff) && ({1'b0, rdb_ff} > bstart_ff);
   assign cntx     = cnt_ff + AW'(cond_cnt);
   assign adv      = ({1'b0, rdb_ff} > bend_ff)
                     && ((IW+1)'(cur_ff) + (IW+1)'(1) < (IW+1)'(MAX_STRINGS));
   assign fin      = !adv && (seq_ff + AW'(1) == sl_ff);

   assign bfirst = bkt_rd_ff[IW+AW-1:AW];
   assign bcount = bkt_rd_ff[AW-1:0];
   assign more   = (i_ff < end_ff) && (i_ff < LW'(sl_ff));
   assign lower  = (i_ff == '0) ? '0 : rda_ff;
   assign hit    = ({1'b0, pos_ff} >= lower) && ({1'b0, pos_ff} < rdb_ff);
   assign jsz    = P'(rt_ff - RW'(1));

   assign rdb_addr = cmd.build_rd ? seq_ff + AW'(1) : i_ff[AW-1:0] + AW'(1);

   always_comb begin
      st.table_ready = tr_ff;
      st.ovf         = rt_ff > LIMIT;
      st.div_done    = div_done;
      st.lk_mode     = lk_mode_ff;
      st.in_range    = q_ext < n_ext;
      st.adv         = adv;
      st.fin         = fin;
      st.more        = more;
      st.hit         = hit;
      st.out_busy    = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      sl_in       = sl_ff;
      rt_in       = rt_ff;
      span_in     = span_ff;
      tr_in       = tr_ff;
      lk_mode_in  = lk_mode_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      seq_in      = seq_ff;
      first_in    = first_ff;
      cnt_in      = cnt_ff;
      bstart_in   = bstart_ff;
      bend_in     = bend_ff;
      lo_off_in   = lo_off_ff;
      last_bkt_in = last_bkt_ff;
      i_in        = i_ff;
      end_in      = end_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_jsz_in    = res_jsz_ff;
      res_span_in   = res_span_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.take_load) begin
         lk_mode_in = 1'b0;
         tr_in      = 1'b0;
         if (tr_ff) begin
            span_in = '0;
         end
         sl_in = sl_base;
         rt_in = rt_base;
         if (room) begin
            sl_in = sl_base + AW'(1);
            rt_in = rt_sat;
         end
      end
      if (cmd.take_lookup) begin
         lk_mode_in = 1'b1;
         pos_in     = req_position;
      end
      if (cmd.set_nr) begin
         res_status_in = ST_NOT_READY;
         res_idx_in    = '0;
         res_jsz_in    = '0;
         res_span_in   = '0;
      end
      if (cmd.set_ovf) begin
         sl_in         = '0;
         rt_in         = '0;
         span_in       = '0;
         res_status_in = ST_OVERFLOW;
         res_idx_in    = '0;
         res_jsz_in    = '1;
         res_span_in   = '0;
      end
      if (cmd.build_init) begin
         span_in   = span_new;
         cur_in    = '0;
         seq_in    = '0;
         first_in  = '0;
         cnt_in    = '0;
         bstart_in = '0;
         bend_in   = RW'(span_new);
         lo_off_in = '0;
      end
      if (cmd.build_step) begin
         if (adv) begin
            cur_in    = cur_ff + IW'(1);
            first_in  = seq_ff[IW-1:0];
            cnt_in    = '0;
            bstart_in = bend_ff;
            bend_in   = bend_ff + RW'(span_ff);
         end else begin
            cnt_in    = cntx;
            lo_off_in = rdb_ff;
            seq_in    = seq_ff + AW'(1);
            if (fin) begin
               last_bkt_in   = cur_ff;
               tr_in         = 1'b1;
               res_status_in = ST_OK;
               res_idx_in    = '0;
               res_jsz_in    = jsz;
               res_span_in   = span_ff[P-1:0];
            end
         end
      end
      if (cmd.lk_init) begin
         i_in   = bvalid_ff ? LW'(bfirst) : '0;
         end_in = bvalid_ff ? LW'(bfirst) + LW'(bcount) : '0;
      end
      if (cmd.lk_next) begin
         i_in = i_ff + LW'(1);
      end
      if (cmd.set_nf) begin
         res_status_in = ST_NOT_FOUND;
         res_idx_in    = '0;
         res_jsz_in    = jsz;
         res_span_in   = span_ff[P-1:0];
      end
      if (cmd.set_hit) begin
         res_status_in = ST_OK;
         res_idx_in    = i_ff;
         res_jsz_in    = jsz;
         res_span_in   = span_ff[P-1:0];
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_load && room) begin
         so_mem[sl_base + AW'(1)] <= rt_sat[DW-1:0];
      end
      if (cmd.so_rd) begin
         rda_ff <= so_mem[i_ff[AW-1:0]];
      end
      if (cmd.so_rd || cmd.build_rd) begin
         rdb_ff <= so_mem[rdb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build_step && (adv || fin)) begin
         bkt_mem[cur_ff] <= {first_ff, cntx};
      end
      if (cmd.bkt_rd) begin
         bkt_rd_ff <= bkt_mem[seg];
         bvalid_ff <= seg <= last_bkt_ff;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      seq_ff        <= seq_in;
      first_ff      <= first_in;
      cnt_ff        <= cnt_in;
      bstart_ff     <= bstart_in;
      bend_ff       <= bend_in;
      lo_off_ff     <= lo_off_in;
      last_bkt_ff   <= last_bkt_in;
      i_ff          <= i_in;
      end_ff        <= end_in;
      lk_mode_ff    <= lk_mode_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_jsz_ff    <= res_jsz_in;
      res_span_ff   <= res_span_in;
      if (cmd.emit) begin
         out_status_ff <= res_status_ff;
         out_idx_ff    <= res_idx_ff;
         out_jsz_ff    <= res_jsz_ff;
         out_span_ff   <= res_span_ff;
      end
      if (reset) begin
         sl_ff        <= '0;
         rt_ff        <= '0;
         span_ff      <= '0;
         tr_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sl_ff        <= sl_in;
         rt_ff        <= rt_in;
         span_ff      <= span_in;
         tr_ff        <= tr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign idx_ext          = {8'b0, out_idx_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_string_index = idx_ext[7:0];
   assign rsp_joined_size  = out_jsz_ff;
   assign rsp_bucket_span  = out_span_ff;

endmodule

FILE: rtl/bptri_ctrl.sv
// Controller state machine that sequences loads, the table build and lookups.
// Depends on bptri_pkg; drives the datapath through cmd_type and reads stat_type.
module bptri_ctrl import bptri_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_type,
   input  logic     req_last_string,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_CHK      = 12'b000000000010,
      S_DIV_GO   = 12'b000000000100,
      S_DIV      = 12'b000000001000,
      S_BLD_INIT = 12'b000000010000,
      S_BLD_RD   = 12'b000000100000,
      S_BLD_STEP = 12'b000001000000,
      S_LK_BKT   = 12'b000010000000,
      S_LK_INIT  = 12'b000100000000,
      S_LK_RD    = 12'b001000000000,
      S_LK_CHK   = 12'b010000000000,
      S_EMIT     = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_LOAD) begin
                  cmd.take_load = 1'b1;
                  if (req_last_string) begin
                     state_in = S_CHK;
                  end
               end else if (!st.table_ready) begin
                  cmd.set_nr = 1'b1;
                  state_in   = S_EMIT;
               end else begin
                  cmd.take_lookup = 1'b1;
                  state_in        = S_DIV_GO;
               end
            end
         end
         S_CHK: begin
            if (st.ovf) begin
               cmd.set_ovf = 1'b1;
               state_in    = S_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (st.div_done) begin
               state_in = st.lk_mode ? S_LK_BKT : S_BLD_INIT;
            end
         end
         S_BLD_INIT: begin
            cmd.build_init = 1'b1;
            state_in       = S_BLD_RD;
         end
         S_BLD_RD: begin
            cmd.build_rd = 1'b1;
            state_in     = S_BLD_STEP;
         end
         S_BLD_STEP: begin
            cmd.build_step = 1'b1;
            if (st.adv) begin
               state_in = S_BLD_STEP;
            end else if (st.fin) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_BLD_RD;
            end
         end
         S_LK_BKT: begin
            if (st.in_range) begin
               cmd.bkt_rd = 1'b1;
               state_in   = S_LK_INIT;
            end else begin
               cmd.set_nf = 1'b1;
               state_in   = S_EMIT;
            end
         end
         S_LK_INIT: begin
            cmd.lk_init = 1'b1;
            state_in    = S_LK_RD;
         end
         S_LK_RD: begin
            if (st.more) begin
               cmd.so_rd = 1'b1;
               state_in  = S_LK_CHK;
            end else begin
               cmd.set_nf = 1'b1;
               state_in   = S_EMIT;
            end
         end
         S_LK_CHK: begin
            if (st.hit) begin
               cmd.set_hit = 1'b1;
               state_in    = S_EMIT;
            end else begin
               cmd.lk_next = 1'b1;
               state_in    = S_LK_RD;
            end
         end
         S_EMIT: begin
            if (!st.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/bucketed_position_to_record_index.sv
// Top level of the bucketed position-to-record index: controller plus datapath.
// Depends on bptri_pkg, bptri_ctrl and bptri_dp.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    req_type, req_str_length, req_last_string,
//                                               req_position
//   rsp_      out        rsp_valid/rsp_ready    rsp_status, rsp_string_index,
//                                               rsp_joined_size, rsp_bucket_span
//
// One request is processed at a time. A load that is not last gives no response.
// A last load runs the span division, then builds the bucket table by reading each
// string's end offset and stepping over the buckets it crosses. A lookup divides the
// position by the span to find its bucket, then scans the strings in that bucket.
// Reset is synchronous; the offset memory is not cleared and needs no clearing pass.
// A waiting result stalls the next result, and requests only while that result is held.
module bucketed_position_to_record_index import bptri_pkg::*; #(
   parameter int MAX_STRINGS = DEF_MAX_STRINGS,
   parameter int POS_BITS    = DEF_POS_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [POS_BITS-1:0] req_str_length,
   input  logic                req_last_string,
   input  logic [POS_BITS-1:0] req_position,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_string_index,
   output logic [POS_BITS-1:0] rsp_joined_size,
   output logic [POS_BITS-1:0] rsp_bucket_span
);

   cmd_type  cmd;
   stat_type st;

   bptri_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_last_string (req_last_string),
      .st              (st),
      .cmd             (cmd)
   );

   bptri_dp #(
      .MAX_STRINGS (MAX_STRINGS),
      .POS_BITS    (POS_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_str_length   (req_str_length),
      .req_position     (req_position),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_string_index (rsp_string_index),
      .rsp_joined_size  (rsp_joined_size),
      .rsp_bucket_span  (rsp_bucket_span)
   );

endmodule

FILE: verif/tb_bucketed_position_to_record_index.sv
// Self-checking testbench for bucketed_position_to_record_index: directed table, then random sets.
// Typed rows hold their responses; a behavioral predictor of build and lookups gives the rest.
// Depends on bptri_pkg and the RTL top level only.
module tb_bucketed_position_to_record_index import bptri_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int      NSTR       = DEF_MAX_STRINGS;
   localparam longint  POS_RANGE  = 64'd1 << DEF_POS_BITS;
   localparam int      CYCLE_CAP  = 3000000;
   localparam int      N_RANDOM   = 930;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  index;
      logic [23:0] joined;
      logic [23:0] span;
   } lookup_rsp_type;

   typedef struct packed {
      logic           kind;
      logic [23:0]    length;
      logic           last;
      logic [23:0]    pos;
      logic           typed;
      lookup_rsp_type want;
   } stim_row_type;

   localparam int N_DIR = 21;
   localparam stim_row_type DIR_ROWS [N_DIR] = '{
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'd0,        1'b1, '{ST_NOT_READY, 8'd0, 24'd0, 24'd0}},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'hFFFFFF,   1'b1, '{ST_NOT_READY, 8'd0, 24'd0, 24'd0}},
      '{REQ_LOAD,   24'd0,        1'b1, 24'd0,        1'b1, '{ST_OK, 8'd0, 24'd0, 24'd1}},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'd0,        1'b1, '{ST_OK, 8'd0, 24'd0, 24'd1}},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'd1,        1'b1, '{ST_NOT_FOUND, 8'd0, 24'd0, 24'd1}},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'hFFFFFF,   1'b1, '{ST_NOT_FOUND, 8'd0, 24'd0, 24'd1}},
      '{REQ_LOAD,   24'hFFFFFF,   1'b1, 24'd0,        1'b1, '{ST_OK, 8'd0, 24'hFFFFFF, 24'd0}},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'hFFFFFF,   1'b1, '{ST_OK, 8'd0, 24'hFFFFFF, 24'd0}},
      '{REQ_LOAD,   24'hFFFFFF,   1'b0, 24'd0,        1'b0, '0},
      '{REQ_LOAD,   24'd0,        1'b1, 24'hFFFFFF,   1'b1, '{ST_OVERFLOW, 8'd0, 24'hFFFFFF, 24'd0}},
      '{REQ_LOOKUP, 24'hFFFFFF,   1'b1, 24'd5,        1'b1, '{ST_NOT_READY, 8'd0, 24'd0, 24'd0}},
      '{REQ_LOAD,   24'd3,        1'b0, 24'd0,        1'b0, '0},
      '{REQ_LOAD,   24'd0,        1'b0, 24'd0,        1'b0, '0},
      '{REQ_LOAD,   24'd7,        1'b0, 24'd0,        1'b0, '0},
      '{REQ_LOAD,   24'd1,        1'b1, 24'd0,        1'b0, '0},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'd3,        1'b0, '0},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'd4,        1'b0, '0},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'd5,        1'b0, '0},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'd13,       1'b0, '0},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'd14,       1'b0, '0},
      '{REQ_LOOKUP, 24'd0,        1'b0, 24'd15,       1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [23:0] req_str_length;
   logic        req_last_string;
   logic [23:0] req_position;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_string_index;
   logic [23:0] rsp_joined_size;
   logic [23:0] rsp_bucket_span;

   longint      offs [NSTR+1];
   int          bkt_first [NSTR];
   int          bkt_count [NSTR];
   int          n_loaded;
   longint      joined_total;
   longint      seg_span;
   bit          index_built;

   lookup_rsp_type pending_rsps [$];
   int          errors;
   int          cycles;
   bit          rsp_calm;

   bucketed_position_to_record_index i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_str_length   (req_str_length),
      .req_last_string  (req_last_string),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_string_index (rsp_string_index),
      .rsp_joined_size  (rsp_joined_size),
      .rsp_bucket_span  (rsp_bucket_span)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic build_index();
      int cur;
      int seq;
      longint lo;
      longint hi;
      seg_span = (joined_total + n_loaded - 1) / n_loaded;
      for (int b = 0; b < NSTR; b++) begin
         bkt_first[b] = 0;
         bkt_count[b] = 0;
      end
      cur = 0;
      seq = 0;
      while (seq < n_loaded) begin
         lo = offs[seq] / seg_span;
         hi = (offs[seq+1] - 1) / seg_span;
         if (lo <= cur && cur <= hi && cur < NSTR) bkt_count[cur]++;
         if (cur < hi && cur + 1 < NSTR) begin
            cur++;
            bkt_first[cur] = seq;
         end else begin
            seq++;
         end
      end
      index_built = 1'b1;
   endtask

   task automatic predict_index(input logic kind, input logic [23:0] length, input logic last,
                                input logic [23:0] pos, output bit has_rsp,
                                output lookup_rsp_type r);
      longint seg;
      int lim;
      has_rsp = 1'b1;
      r = '0;
      if (kind == REQ_LOAD) begin
         if (index_built) begin
            index_built = 1'b0;
            n_loaded = 0;
            joined_total = 0;
            seg_span = 0;
         end
         if (n_loaded < NSTR) begin
            offs[n_loaded] = joined_total;
            joined_total += longint'(length) + 1;
            if (joined_total > POS_RANGE) joined_total = POS_RANGE + 1;
            n_loaded++;
            offs[n_loaded] = joined_total;
         end
         if (!last) begin
            has_rsp = 1'b0;
         end else if (joined_total > POS_RANGE) begin
            n_loaded = 0;
            joined_total = 0;
            seg_span = 0;
            r = '{ST_OVERFLOW, 8'd0, 24'hFFFFFF, 24'd0};
         end else begin
            build_index();
            r = '{ST_OK, 8'd0, 24'(joined_total - 1), 24'(seg_span)};
         end
      end else if (!index_built) begin
         r = '{ST_NOT_READY, 8'd0, 24'd0, 24'd0};
      end else begin
         r = '{ST_NOT_FOUND, 8'd0, 24'(joined_total - 1), 24'(seg_span)};
         seg = longint'(pos) / seg_span;
         if (seg < n_loaded) begin
            lim = bkt_first[seg] + bkt_count[seg];
            for (int i = bkt_first[seg]; i < lim && i < n_loaded; i++) begin
               if (pos >= offs[i] && pos < offs[i+1]) begin
                  r.status = ST_OK;
                  r.index = 8'(i);
                  break;
               end
            end
         end
      end
   endtask

   task automatic send_request(input logic kind, input logic [23:0] length, input logic last,
                               input logic [23:0] pos, input bit typed,
                               input lookup_rsp_type want);
      int gap;
      bit has_rsp;
      lookup_rsp_type r;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_str_length  <= length;
      req_last_string <= last;
      req_position    <= pos;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_index(kind, length, last, pos, has_rsp, r);
      if (has_rsp) pending_rsps.push_back(typed ? want : r);
   endtask

   task automatic drain_rsps();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsps.size() != 0);
   endtask

   initial begin
      int rsp_gap;
      rsp_ready = 1'b0;
      rsp_gap = 0;
      forever begin
         @(posedge clock);
         if (rsp_calm) begin
            rsp_ready <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               rsp_gap = ($urandom_range(0, 12) == 0) ? $urandom_range(10, 50)
                                                       : $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      lookup_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $error("response with no request outstanding: status %0d", rsp_status);
            errors++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_string_index !== want.index) begin
               $error("string_index: expected %0d, actual %0d", want.index, rsp_string_index);
               errors++;
            end
            if (rsp_joined_size !== want.joined) begin
               $error("joined_size: expected %0d, actual %0d", want.joined, rsp_joined_size);
               errors++;
            end
            if (rsp_bucket_span !== want.span) begin
               $error("bucket_span: expected %0d, actual %0d", want.span, rsp_bucket_span);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int sent;
      int set_size;
      int n_lookups;
      int pick;
      int big_sets;
      logic [23:0] length;
      logic [23:0] pos;
      errors = 0;
      cycles = 0;
      rsp_calm = 1'b0;
      index_built = 1'b0;
      n_loaded = 0;
      joined_total = 0;
      seg_span = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_LOAD;
      req_str_length = '0;
      req_last_string = 1'b0;
      req_position = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < N_DIR; k++)
         send_request(DIR_ROWS[k].kind, DIR_ROWS[k].length, DIR_ROWS[k].last,
                      DIR_ROWS[k].pos, DIR_ROWS[k].typed, DIR_ROWS[k].want);
      drain_rsps();

      sent = 0;
      big_sets = 0;
      while (sent < N_RANDOM) begin
         pick = $urandom_range(0, 99);
         if (pick < 3 && big_sets < 3) begin
            set_size = $urandom_range(250, 260);
            big_sets++;
         end else if (pick < 25) begin
            set_size = $urandom_range(7, 40);
         end else begin
            set_size = $urandom_range(1, 6);
         end
         if (set_size > N_RANDOM - sent) set_size = N_RANDOM - sent;
         rsp_calm = ($urandom_range(0, 5) == 0);
         for (int s = 0; s < set_size; s++) begin
            if ($urandom_range(0, 19) == 0) begin
               send_request(REQ_LOOKUP, 24'($urandom), 1'($urandom), 24'($urandom), 1'b0, '0);
               sent++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4 || (set_size == 1 && pick < 30)) length = 24'($urandom);
            else if (pick < 10) length = 24'($urandom_range(0, 4000));
            else length = 24'($urandom_range(0, 30));
            send_request(REQ_LOAD, length, 1'(s == set_size - 1), 24'($urandom), 1'b0, '0);
            sent++;
         end
         n_lookups = $urandom_range(3, 10);
         for (int q = 0; q < n_lookups; q++) begin
            pick = $urandom_range(0, 9);
            if (!index_built || pick == 0) pos = 24'($urandom);
            else if (pick == 1) pos = 24'(joined_total + $urandom_range(0, 5));
            else pos = 24'($urandom_range(0, int'(joined_total - 1)));
            send_request(REQ_LOOKUP, 24'($urandom), 1'($urandom), pos, 1'b0, '0);
            sent++;
         end
         if ($urandom_range(0, 24) == 0) drain_rsps();
      end

      drain_rsps();
      repeat (700) @(posedge clock);
      if (errors == 0 && pending_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/bptri_pkg.sv
rtl/bptri_div.sv
rtl/bptri_dp.sv
rtl/bptri_ctrl.sv
rtl/bucketed_position_to_record_index.sv
verif/tb_bucketed_position_to_record_index.sv
